>>> design/gdl_pkg.sv
// Shared types, constants and helpers for the grid diffusion Laplacian block.
// No dependencies; every design file refers to this package by scoped names.
package gdl_pkg;

  // Grid limits and store geometry
  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_LAYERS  = 16;
  localparam int STORE_DEPTH = MAX_LAYERS * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int LAYER_W    = 4;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 16;
  localparam int COEFF_W    = 16;
  localparam int CNT_W      = 3;
  localparam int TERM_W     = 20;
  localparam int LAYER_SZ_W = 5;
  localparam int ROW_SZ_W   = 7;
  localparam int COL_SZ_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Sequencer steps: step 0 reads the voxel itself, steps 1..6 the faces
  localparam int NUM_FACES = 6;
  localparam int STEP_W    = $clog2(NUM_FACES + 1);
  localparam int FACE_W    = $clog2(NUM_FACES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_FACES);

  // Face offsets
  localparam logic signed [1:0] D_ROW   [NUM_FACES] = '{2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0};
  localparam logic signed [1:0] D_COL   [NUM_FACES] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] D_LAYER [NUM_FACES] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1};

  // Opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_MUL
  } state_t;

  // Datapath controls issued by the sequencer
  typedef struct packed {
    logic clear;     // new compute item: zero accumulator and count
    logic own_load;  // read data is the voxel's own value
    logic nb_add;    // read data is an in-grid neighbour
    logic finish;    // multiply and load the result registers
  } ctrl_t;

  // Linear store address of a voxel
  function automatic logic [ADDR_W-1:0] addr_of(input logic [LAYER_W-1:0] l,
                                                input logic [ROW_W-1:0]   r,
                                                input logic [COL_W-1:0]   c);
    addr_of = ADDR_W'((int'(l) * MAX_ROWS + int'(r)) * MAX_COLS + int'(c));
  endfunction

endpackage

>>> design/gdl_store.sv
// Single-port voxel store, registered read data.
// Depends on gdl_pkg for depth and widths.
module gdl_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [gdl_pkg::ADDR_W-1:0] addr,
  input  logic [gdl_pkg::VAL_W-1:0]  wdata,
  output logic [gdl_pkg::VAL_W-1:0]  rdata
);

  logic [gdl_pkg::VAL_W-1:0] mem [gdl_pkg::STORE_DEPTH];

  // One access per cycle: write or read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/gdl_seq.sv
// Sequencer: accepts items, walks the voxel and its six faces over the store port.
// Depends on gdl_pkg for types, face offsets and address helper.
module gdl_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           opcode,
  input  logic [gdl_pkg::LAYER_W-1:0]    layer,
  input  logic [gdl_pkg::ROW_W-1:0]      row,
  input  logic [gdl_pkg::COL_W-1:0]      col,
  input  logic [gdl_pkg::VAL_W-1:0]      value,
  input  logic [gdl_pkg::COL_SZ_W-1:0]   cols_used,
  input  logic [gdl_pkg::ROW_SZ_W-1:0]   rows_used,
  input  logic [gdl_pkg::LAYER_SZ_W-1:0] layers_used,
  output logic                           busy,
  output logic                           mem_we,
  output logic [gdl_pkg::ADDR_W-1:0]     mem_addr,
  output logic [gdl_pkg::VAL_W-1:0]      mem_wdata,
  output gdl_pkg::ctrl_t                 ctrl,
  output logic [gdl_pkg::LAYER_W-1:0]    cur_layer,
  output logic [gdl_pkg::ROW_W-1:0]      cur_row,
  output logic [gdl_pkg::COL_W-1:0]      cur_col
);

  gdl_pkg::state_t state, state_next;
  logic [gdl_pkg::STEP_W-1:0] step, step_next;
  logic tag_own, tag_nb;

  logic [gdl_pkg::LAYER_SZ_W-1:0] nl;
  logic [gdl_pkg::ROW_SZ_W-1:0]   nr;
  logic [gdl_pkg::COL_SZ_W-1:0]   nc;
  logic accept, in_grid, in_store, go_compute;

  logic [gdl_pkg::FACE_W-1:0]      face;
  logic signed [gdl_pkg::LAYER_W+1:0] ql;
  logic signed [gdl_pkg::ROW_W+1:0]   qr;
  logic signed [gdl_pkg::COL_W+1:0]   qc;
  logic nb_ok;
  logic [gdl_pkg::ADDR_W-1:0] rd_addr;

  // Sizes in use, saturated at the store limits
  always_comb begin
    nl = (32'(layers_used) > gdl_pkg::MAX_LAYERS) ?
         gdl_pkg::LAYER_SZ_W'(gdl_pkg::MAX_LAYERS) : layers_used;
    nr = (32'(rows_used) > gdl_pkg::MAX_ROWS) ?
         gdl_pkg::ROW_SZ_W'(gdl_pkg::MAX_ROWS) : rows_used;
    nc = (32'(cols_used) > gdl_pkg::MAX_COLS) ?
         gdl_pkg::COL_SZ_W'(gdl_pkg::MAX_COLS) : cols_used;
  end

  // Item acceptance and address checks
  assign busy       = (state != gdl_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign in_grid    = ({1'b0, layer} < nl) && ({1'b0, row} < nr) && ({1'b0, col} < nc);
  assign in_store   = (32'(layer) < gdl_pkg::MAX_LAYERS) && (32'(row) < gdl_pkg::MAX_ROWS) &&
                      (32'(col) < gdl_pkg::MAX_COLS);
  assign go_compute = accept && (opcode == gdl_pkg::OP_COMPUTE) && in_grid;

  // Neighbour coordinates for the current step
  always_comb begin
    face  = gdl_pkg::FACE_W'(step - gdl_pkg::STEP_W'(1));
    ql    = $signed({2'b00, cur_layer}) + (gdl_pkg::LAYER_W+2)'(gdl_pkg::D_LAYER[face]);
    qr    = $signed({2'b00, cur_row})   + (gdl_pkg::ROW_W+2)'(gdl_pkg::D_ROW[face]);
    qc    = $signed({2'b00, cur_col})   + (gdl_pkg::COL_W+2)'(gdl_pkg::D_COL[face]);
    nb_ok = !ql[gdl_pkg::LAYER_W+1] && (ql[gdl_pkg::LAYER_W:0] < nl) &&
            !qr[gdl_pkg::ROW_W+1]   && (qr[gdl_pkg::ROW_W:0]   < nr) &&
            !qc[gdl_pkg::COL_W+1]   && (qc[gdl_pkg::COL_W:0]   < nc);
    if (step == '0) begin
      rd_addr = gdl_pkg::addr_of(cur_layer, cur_row, cur_col);
    end else begin
      rd_addr = gdl_pkg::addr_of(ql[gdl_pkg::LAYER_W-1:0], qr[gdl_pkg::ROW_W-1:0],
                                 qc[gdl_pkg::COL_W-1:0]);
    end
  end

  // Store port: writes while idle, sequenced reads otherwise
  always_comb begin
    mem_wdata = value;
    if (state == gdl_pkg::ST_IDLE) begin
      mem_we   = accept && (opcode == gdl_pkg::OP_WRITE) && in_store;
      mem_addr = gdl_pkg::addr_of(layer, row, col);
    end else begin
      mem_we   = 1'b0;
      mem_addr = rd_addr;
    end
  end

  // State register and read tags
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gdl_pkg::ST_IDLE;
      step    <= '0;
      tag_own <= 1'b0;
      tag_nb  <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      tag_own <= (state == gdl_pkg::ST_RUN) && (step == '0);
      tag_nb  <= (state == gdl_pkg::ST_RUN) && (step != '0) && nb_ok;
    end
  end

  // Coordinates of the item in progress
  always_ff @(posedge clk) begin
    if (go_compute) begin
      cur_layer <= layer;
      cur_row   <= row;
      cur_col   <= col;
    end
  end

  // Next state and datapath controls
  always_comb begin
    state_next    = state;
    step_next     = step;
    ctrl.clear    = go_compute;
    ctrl.own_load = tag_own;
    ctrl.nb_add   = tag_nb;
    ctrl.finish   = 1'b0;
    case (state)
      gdl_pkg::ST_IDLE: begin
        if (go_compute) begin
          state_next = gdl_pkg::ST_RUN;
          step_next  = '0;
        end
      end
      gdl_pkg::ST_RUN: begin
        if (step == gdl_pkg::LAST_STEP) begin
          state_next = gdl_pkg::ST_DRAIN;
        end else begin
          step_next = step + gdl_pkg::STEP_W'(1);
        end
      end
      gdl_pkg::ST_DRAIN: begin
        state_next = gdl_pkg::ST_MUL;
      end
      gdl_pkg::ST_MUL: begin
        ctrl.finish = 1'b1;
        state_next  = gdl_pkg::ST_IDLE;
      end
      default: begin
        state_next = gdl_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    (state == gdl_pkg::ST_RUN && step != gdl_pkg::LAST_STEP) |=>
      (state == gdl_pkg::ST_RUN && step == $past(step) + gdl_pkg::STEP_W'(1)))
    else $error("step counter skipped during neighbour walk");

  a_tags_excl: assert property (@(posedge clk) disable iff (rst)
    !(tag_own && tag_nb))
    else $error("own and neighbour reads tagged in the same cycle");

  a_own_first: assert property (@(posedge clk) disable iff (rst)
    go_compute |=> (state == gdl_pkg::ST_RUN && step == '0))
    else $error("compute item did not start at the own-value read");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !mem_we)
    else $error("store written during a compute item");

endmodule

>>> design/gdl_datapath.sv
// Accumulator, coefficient multiplier and result registers.
// Depends on gdl_pkg for widths and the control struct.
module gdl_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  gdl_pkg::ctrl_t               ctrl,
  input  logic [gdl_pkg::VAL_W-1:0]    mem_rdata,
  input  logic [gdl_pkg::COEFF_W-1:0]  coeff,
  input  logic [gdl_pkg::LAYER_W-1:0]  cur_layer,
  input  logic [gdl_pkg::ROW_W-1:0]    cur_row,
  input  logic [gdl_pkg::COL_W-1:0]    cur_col,
  output logic                         done,
  output logic [gdl_pkg::LAYER_W-1:0]  out_layer,
  output logic [gdl_pkg::ROW_W-1:0]    out_row,
  output logic [gdl_pkg::COL_W-1:0]    out_col,
  output logic [gdl_pkg::CNT_W-1:0]    neighbour_count,
  output logic signed [gdl_pkg::TERM_W-1:0] diff_term
);

  logic [gdl_pkg::VAL_W-1:0]         own;
  logic signed [gdl_pkg::TERM_W-1:0] acc;
  logic [gdl_pkg::CNT_W-1:0]         count;
  logic signed [gdl_pkg::TERM_W-1:0] nb_ext, own_ext, step_diff;
  logic signed [gdl_pkg::TERM_W+gdl_pkg::COEFF_W:0] prod;

  // Shared adder: each neighbour adds (neighbour - own)
  always_comb begin
    nb_ext    = $signed(gdl_pkg::TERM_W'(mem_rdata));
    own_ext   = $signed(gdl_pkg::TERM_W'(own));
    step_diff = nb_ext - own_ext;
    prod      = acc * $signed({1'b0, coeff});
  end

  // Accumulation
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc   <= '0;
      count <= '0;
    end else if (ctrl.nb_add) begin
      acc   <= acc + step_diff;
      count <= count + gdl_pkg::CNT_W'(1);
    end
    if (ctrl.own_load) begin
      own <= mem_rdata;
    end
  end

  // Result registers; arithmetic shift by 16 rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_layer       <= cur_layer;
      out_row         <= cur_row;
      out_col         <= cur_col;
      neighbour_count <= count;
      diff_term       <= prod[gdl_pkg::TERM_W+gdl_pkg::COEFF_W-1:gdl_pkg::COEFF_W];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

endmodule

>>> design/grid_diffusion_laplacian.sv
// Top level of the grid diffusion Laplacian block.
// Depends on gdl_pkg, gdl_store, gdl_seq and gdl_datapath.

// A write item is accepted and busy stays low. A compute item for a voxel
// inside the grid in use raises busy for seven reads on the single store port
// (the voxel, then its six faces, one per cycle), the drain state to take the
// last read and the MUL state for the coefficient multiply; done then strobes
// for one cycle with the result and busy is already low, so the next item can
// be accepted while done is high. A compute item outside the grid in use is
// accepted and gives no result. done marks each result for exactly one cycle
// and cannot be held off. The store has no reset or clearing pass: every voxel
// that a compute item touches must have been written first. Configuration
// must be written only while the block is idle; the block does not check it.
module grid_diffusion_laplacian (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [gdl_pkg::LAYER_W-1:0]      layer,
  input  logic [gdl_pkg::ROW_W-1:0]        row,
  input  logic [gdl_pkg::COL_W-1:0]        col,
  input  logic [gdl_pkg::VAL_W-1:0]        value,
  output logic                             done,
  output logic [gdl_pkg::LAYER_W-1:0]      out_layer,
  output logic [gdl_pkg::ROW_W-1:0]        out_row,
  output logic [gdl_pkg::COL_W-1:0]        out_col,
  output logic [gdl_pkg::CNT_W-1:0]        neighbour_count,
  output logic signed [gdl_pkg::TERM_W-1:0] diff_term,
  input  logic                             cfg_we,
  input  logic [gdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [gdl_pkg::COEFF_W-1:0]    diffusion_coeff;
  logic [gdl_pkg::COL_SZ_W-1:0]   cols_used;
  logic [gdl_pkg::ROW_SZ_W-1:0]   rows_used;
  logic [gdl_pkg::LAYER_SZ_W-1:0] layers_used;

  logic                       mem_we;
  logic [gdl_pkg::ADDR_W-1:0] mem_addr;
  logic [gdl_pkg::VAL_W-1:0]  mem_wdata, mem_rdata;
  gdl_pkg::ctrl_t             ctrl;
  logic [gdl_pkg::LAYER_W-1:0] cur_layer;
  logic [gdl_pkg::ROW_W-1:0]   cur_row;
  logic [gdl_pkg::COL_W-1:0]   cur_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_coeff <= '0;
      cols_used       <= gdl_pkg::COL_SZ_W'(64);
      rows_used       <= gdl_pkg::ROW_SZ_W'(64);
      layers_used     <= gdl_pkg::LAYER_SZ_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        gdl_pkg::REG_COEFF:  diffusion_coeff <= cfg_data[gdl_pkg::COEFF_W-1:0];
        gdl_pkg::REG_COLS:   cols_used       <= cfg_data[gdl_pkg::COL_SZ_W-1:0];
        gdl_pkg::REG_ROWS:   rows_used       <= cfg_data[gdl_pkg::ROW_SZ_W-1:0];
        gdl_pkg::REG_LAYERS: layers_used     <= cfg_data[gdl_pkg::LAYER_SZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gdl_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .layer       (layer),
    .row         (row),
    .col         (col),
    .value       (value),
    .cols_used   (cols_used),
    .rows_used   (rows_used),
    .layers_used (layers_used),
    .busy        (busy),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .ctrl        (ctrl),
    .cur_layer   (cur_layer),
    .cur_row     (cur_row),
    .cur_col     (cur_col)
  );

  gdl_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  gdl_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .mem_rdata       (mem_rdata),
    .coeff           (diffusion_coeff),
    .cur_layer       (cur_layer),
    .cur_row         (cur_row),
    .cur_col         (cur_col),
    .done            (done),
    .out_layer       (out_layer),
    .out_row         (out_row),
    .out_col         (out_col),
    .neighbour_count (neighbour_count),
    .diff_term       (diff_term)
  );

endmodule
